### hw/rtl/res_pkg.sv
package res_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int KEY_BITS    = 16;
   localparam int TAG_BITS    = 6;
   localparam int IDX_BITS    = $clog2(MAX_RECORDS);
   localparam int CNT_BITS    = $clog2(MAX_RECORDS + 1);

   typedef struct packed {
      logic [KEY_BITS-1:0] sort_key;
      logic [TAG_BITS-1:0] record_tag;
      logic                batch_end;
   } req_word_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] sorted_key;
      logic [TAG_BITS-1:0] sorted_tag;
      logic                run_end;
   } rsp_word_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } rec_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH_I,
      ST_LATCH_I,
      ST_FETCH_J,
      ST_CMP,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_HOLD
   } state_type;

endpackage

### hw/rtl/record_exchange_sorter.sv
// channel   | direction | word          | handshake
// req_      | in        | req_word_type | req_valid / req_ready
// rsp_      | out       | rsp_word_type | rsp_valid / rsp_ready
//
// loading takes one cycle per word while req_ready is high; records past 64 are dropped
// sort over n records: each outer pass latches record i, then fetches and compares
// each later record on the single ram port pair, writing the smaller key back at i
// each sorted word then passes through the ram read and output register
// synchronous reset clears the sequencer, count and rsp_valid; the ram is not cleared
// req_ready is low from the closing word until the last sorted word is taken;
// rsp_ready low holds the output word
module record_exchange_sorter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  res_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output res_pkg::rsp_word_type rsp_data
);
   import res_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   n_ff, n_in;
   logic [IDX_BITS-1:0]   i_ff, i_in;
   logic [CNT_BITS-1:0]   j_ff, j_in;
   logic [IDX_BITS-1:0]   k_ff, k_in;
   rec_type               cur_ff, cur_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   rec_type               wr_data;
   logic [IDX_BITS-1:0]   rd_addr;
   rec_type               rd_data;

   logic                  req_take;
   logic                  full;
   logic [CNT_BITS-1:0]   cnt_now;
   logic                  j_done;
   logic                  pass_last;

   assign req_take  = (state_ff == ST_LOAD) && req_valid;
   assign full      = (count_ff == CNT_BITS'(MAX_RECORDS));
   assign cnt_now   = full ? count_ff : count_ff + CNT_BITS'(1);
   assign j_done    = (j_ff == n_ff);
   assign pass_last = (CNT_BITS'(i_ff) + CNT_BITS'(2) == n_ff);

   res_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take && req_data.batch_end) begin
               state_in = (cnt_now == CNT_BITS'(1)) ? ST_OUT_RD : ST_FETCH_I;
            end
         end
         ST_FETCH_I: state_in = ST_LATCH_I;
         ST_LATCH_I: state_in = ST_FETCH_J;
         ST_FETCH_J: begin
            if (j_done) begin
               state_in = pass_last ? ST_OUT_RD : ST_FETCH_I;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP:    state_in = ST_FETCH_J;
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: state_in = ST_OUT_HOLD;
         ST_OUT_HOLD: begin
            if (rsp_ready) begin
               state_in = rsp_data_ff.run_end ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and ram control
   always_comb begin
      count_in     = count_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff;
      wr_data      = cur_ff;
      rd_addr      = i_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (!full) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_BITS-1:0];
                  wr_data  = '{key: req_data.sort_key, tag: req_data.record_tag};
                  count_in = cnt_now;
               end
               if (req_data.batch_end) begin
                  n_in     = cnt_now;
                  count_in = '0;
                  i_in     = '0;
                  k_in     = '0;
               end
            end
         end
         ST_FETCH_I: rd_addr = i_ff;
         ST_LATCH_I: begin
            cur_in = rd_data;
            j_in   = CNT_BITS'(i_ff) + CNT_BITS'(1);
         end
         ST_FETCH_J: begin
            if (j_done) begin
               wr_en   = 1'b1;
               wr_addr = i_ff;
               wr_data = cur_ff;
               i_in    = i_ff + IDX_BITS'(1);
            end else begin
               rd_addr = j_ff[IDX_BITS-1:0];
            end
         end
         ST_CMP: begin
            if (cur_ff.key > rd_data.key) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[IDX_BITS-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            j_in = j_ff + CNT_BITS'(1);
         end
         ST_OUT_RD: rd_addr = k_ff;
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{sorted_key: rd_data.key,
                             sorted_tag: rd_data.tag,
                             run_end:    (CNT_BITS'(k_ff) + CNT_BITS'(1) == n_ff)};
         end
         ST_OUT_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               k_in         = k_ff + IDX_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/res_ram.sv
module res_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [res_pkg::IDX_BITS-1:0] wr_addr,
   input  res_pkg::rec_type             wr_data,
   input  logic [res_pkg::IDX_BITS-1:0] rd_addr,
   output res_pkg::rec_type             rd_data
);
   import res_pkg::*;

   rec_type mem [MAX_RECORDS];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/record_exchange_sorter_chk.sv
module record_exchange_sorter_chk (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input res_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input res_pkg::rsp_word_type rsp_data
);
   import res_pkg::*;

   // a waiting word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // nothing comes out straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // no loading while sorted words are being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high with a word pending");

   // closing word ends loading and starts the sort, or the output for a single record
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.batch_end |=> !req_ready)
      else $error("req_ready stayed high after batch end");

endmodule

bind record_exchange_sorter record_exchange_sorter_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
